// ===== rtl/length_prefixed_frame_decoder_core_assert.svh =====
// Assertion macros for the length-prefixed frame decoder.
`ifndef LENGTH_PREFIXED_FRAME_DECODER_CORE_ASSERT_SVH
`define LENGTH_PREFIXED_FRAME_DECODER_CORE_ASSERT_SVH

// Property must hold at every clock edge outside reset.
`define LPFD_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("%m: check failed");

// Expression must never be true outside reset.
`define LPFD_ASSERT_NEVER(name, clk, rst, expr) \
   name: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("%m: forbidden condition seen");

`endif

// ===== rtl/lpfd_pkg.sv =====
// Shared types and constants of the length-prefixed frame decoder.
package lpfd_pkg;

   localparam int HEADER_BYTES_DEF = 4;
   localparam logic [31:0] MAX_PAYLOAD_RESET = 32'd16777216;

   typedef enum logic [1:0] {
      KIND_DATA  = 2'd0,
      KIND_EMPTY = 2'd1,
      KIND_ERROR = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  data_byte;
      logic [7:0]  frame_type;
      logic [31:0] frame_length;
      logic        last;
   } rsp_type;

endpackage

// ===== rtl/length_prefixed_frame_decoder_core.sv =====
// Length-prefixed frame decoder: header, type byte, payload; one item per cycle if ready.
//
// Takes one stream byte per cycle while req_ready is high. HEADER_BYTES little-endian
// header bytes give the payload length, the next byte is the frame type, and then that
// many payload bytes come out tagged with type and length, the final one marked last.
// A zero-length frame gives one empty-frame result on its type byte; a length above
// max_payload gives one error result on the last header byte and header collection
// restarts. Each item is handled in the cycle it is accepted: one 32-bit compare and
// counter step sit between the state registers and a two-entry output buffer, which
// registers the result; req_ready drops only when both buffer entries are full.

module length_prefixed_frame_decoder_core
   import lpfd_pkg::*;
#(
   parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_in_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_result_kind,
   output logic [7:0]       rsp_data_byte,
   output logic [7:0]       rsp_frame_type,
   output logic [31:0]      rsp_frame_length,
   output logic             rsp_last_of_frame,
   input  wire logic        csr_write_enable,
   input  wire logic [31:0] csr_write_data
);

   localparam int HCNT_W = (HEADER_BYTES > 1) ? $clog2(HEADER_BYTES) : 1;

   typedef enum logic [1:0] {
      PH_HEADER  = 2'd0,
      PH_TYPE    = 2'd1,
      PH_PAYLOAD = 2'd2
   } phase_type;

   phase_type          phase_ff, phase_in;
   logic [HCNT_W-1:0]  hcnt_ff, hcnt_in;
   logic [31:0]        length_ff, length_in;
   logic [7:0]         type_ff, type_in;
   logic [31:0]        pcnt_ff, pcnt_in;
   logic [31:0]        max_payload_ff;

   rsp_type            out_ff, skid_ff, res;
   logic               out_valid_ff, skid_valid_ff;
   logic               accept, pop, res_push;

   logic [HCNT_W-1:0]  hdr_cnt;
   logic [31:0]        hdr_base, hdr_len;
   logic               hdr_last, pay_last;

   assign req_ready = !skid_valid_ff;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = out_valid_ff;
   assign pop       = out_valid_ff && rsp_ready;

   assign rsp_result_kind   = out_ff.kind;
   assign rsp_data_byte     = out_ff.data_byte;
   assign rsp_frame_type    = out_ff.frame_type;
   assign rsp_frame_length  = out_ff.frame_length;
   assign rsp_last_of_frame = out_ff.last;

   // header byte merge; an unused phase code restarts the header
   always_comb begin
      hdr_cnt  = (phase_ff == PH_HEADER) ? hcnt_ff : '0;
      hdr_base = (phase_ff == PH_HEADER) ? length_ff : '0;
      hdr_len  = hdr_base;
      for (int lane = 0; lane < 4; lane++) begin
         if (int'(hdr_cnt) == lane) begin
            hdr_len[lane*8 +: 8] = hdr_base[lane*8 +: 8] | req_in_byte;
         end
      end
      if (int'(hdr_cnt) >= 4 && req_in_byte != 8'd0) begin
         hdr_len = '1;
      end
      hdr_last = (int'(hdr_cnt) == HEADER_BYTES - 1);
   end

   assign pay_last = ((pcnt_ff + 32'd1) == length_ff);

   always_comb begin
      phase_in  = phase_ff;
      hcnt_in   = hcnt_ff;
      length_in = length_ff;
      type_in   = type_ff;
      pcnt_in   = pcnt_ff;
      res_push  = 1'b0;
      res       = '{kind: KIND_DATA, data_byte: 8'd0, frame_type: 8'd0,
                    frame_length: 32'd0, last: 1'b0};
      if (accept) begin
         unique case (phase_ff)
            PH_TYPE: begin
               type_in = req_in_byte;
               if (length_ff == 32'd0) begin
                  res_push       = 1'b1;
                  res.kind       = KIND_EMPTY;
                  res.frame_type = req_in_byte;
                  res.last       = 1'b1;
                  phase_in       = PH_HEADER;
                  hcnt_in        = '0;
                  length_in      = '0;
                  pcnt_in        = '0;
               end else begin
                  pcnt_in  = '0;
                  phase_in = PH_PAYLOAD;
               end
            end
            PH_PAYLOAD: begin
               res_push         = 1'b1;
               res.kind         = KIND_DATA;
               res.data_byte    = req_in_byte;
               res.frame_type   = type_ff;
               res.frame_length = length_ff;
               res.last         = pay_last;
               if (pay_last) begin
                  phase_in  = PH_HEADER;
                  hcnt_in   = '0;
                  length_in = '0;
                  pcnt_in   = '0;
               end else begin
                  pcnt_in = pcnt_ff + 32'd1;
               end
            end
            default: begin
               phase_in = PH_HEADER;
               pcnt_in  = '0;
               if (hdr_last) begin
                  hcnt_in = '0;
                  if (hdr_len > max_payload_ff) begin
                     res_push         = 1'b1;
                     res.kind         = KIND_ERROR;
                     res.frame_length = hdr_len;
                     length_in        = '0;
                  end else begin
                     length_in = hdr_len;
                     phase_in  = PH_TYPE;
                  end
               end else begin
                  hcnt_in   = hdr_cnt + HCNT_W'(1);
                  length_in = hdr_len;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_HEADER;
         hcnt_ff        <= '0;
         length_ff      <= '0;
         type_ff        <= '0;
         pcnt_ff        <= '0;
         max_payload_ff <= MAX_PAYLOAD_RESET;
         out_valid_ff   <= 1'b0;
         skid_valid_ff  <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         hcnt_ff   <= hcnt_in;
         length_ff <= length_in;
         type_ff   <= type_in;
         pcnt_ff   <= pcnt_in;
         if (csr_write_enable) begin
            max_payload_ff <= csr_write_data;
         end
         // two-entry output buffer: out_ff is the head, skid_ff the overflow
         if (pop) begin
            if (skid_valid_ff) begin
               out_ff        <= skid_ff;
               skid_valid_ff <= 1'b0;
            end else if (res_push) begin
               out_ff <= res;
            end else begin
               out_valid_ff <= 1'b0;
            end
         end else if (res_push) begin
            if (!out_valid_ff) begin
               out_ff       <= res;
               out_valid_ff <= 1'b1;
            end else begin
               skid_ff       <= res;
               skid_valid_ff <= 1'b1;
            end
         end
      end
   end

`include "length_prefixed_frame_decoder_core_assert.svh"

   `LPFD_ASSERT(a_skid_behind_head, clock, reset, skid_valid_ff |-> out_valid_ff)
   `LPFD_ASSERT(a_payload_in_range, clock, reset,
      (phase_ff == PH_PAYLOAD) |-> (pcnt_ff < length_ff))
   `LPFD_ASSERT(a_hcnt_idle, clock, reset, (phase_ff != PH_HEADER) |-> (hcnt_ff == '0))
   `LPFD_ASSERT_NEVER(a_empty_shape, clock, reset,
      out_valid_ff && out_ff.kind == KIND_EMPTY &&
      (!out_ff.last || out_ff.frame_length != 32'd0))

endmodule

// ===== verif/length_prefixed_frame_decoder_core_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the length-prefixed frame decoder core.
module length_prefixed_frame_decoder_core_tb;
   import lpfd_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int RANDOM_ITEMS = 1600;
   localparam int PHASES = 6;
   localparam int DIRECTED_ROWS = 26;
   localparam rsp_type NO_RSP = '0;

   typedef enum logic [1:0] {
      ST_HEADER  = 2'd0,
      ST_TYPE    = 2'd1,
      ST_PAYLOAD = 2'd2
   } dec_phase_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       typed;
      rsp_type    want;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic [7:0]  req_in_byte = 8'h00;
   logic        rsp_ready = 1'b0;
   logic        csr_write_enable = 1'b0;
   logic [31:0] csr_write_data = 32'h0;
   logic        req_ready;
   logic        rsp_valid;
   logic [1:0]  rsp_result_kind;
   logic [7:0]  rsp_data_byte;
   logic [7:0]  rsp_frame_type;
   logic [31:0] rsp_frame_length;
   logic        rsp_last_of_frame;

   // item currently offered, with its hand-written expectation if any
   logic        row_typed = 1'b0;
   rsp_type     row_want = NO_RSP;

   int tx_idle_pct = 24;
   int rx_idle_pct = 45;
   int items_sent = 0;
   int mismatches = 0;
   int cycle_count = 0;

   // decoder shadow state
   dec_phase_type dec_phase = ST_HEADER;
   logic [3:0]  hdr_count = '0;
   logic [31:0] frame_len = '0;
   logic [7:0]  frame_type_q = '0;
   logic [31:0] bytes_passed = '0;
   logic [31:0] max_payload_q = MAX_PAYLOAD_RESET;

   rsp_type pending_results[$];
   rsp_type predicted_rsp;
   rsp_type oldest_rsp;

   stim_row_type stim_rows [DIRECTED_ROWS] = '{
      {8'hFF, 1'b0, NO_RSP},
      {8'hFF, 1'b0, NO_RSP},
      {8'hFF, 1'b0, NO_RSP},
      {8'hFF, 1'b1, {KIND_ERROR, 8'h00, 8'h00, 32'hFFFF_FFFF, 1'b0}},
      {8'h01, 1'b0, NO_RSP},
      {8'h00, 1'b0, NO_RSP},
      {8'h00, 1'b0, NO_RSP},
      {8'h01, 1'b1, {KIND_ERROR, 8'h00, 8'h00, 32'h0100_0001, 1'b0}},
      {8'h00, 1'b0, NO_RSP},
      {8'h00, 1'b0, NO_RSP},
      {8'h00, 1'b0, NO_RSP},
      {8'h00, 1'b0, NO_RSP},
      {8'hFF, 1'b1, {KIND_EMPTY, 8'h00, 8'hFF, 32'h0000_0000, 1'b1}},
      {8'h01, 1'b0, NO_RSP},
      {8'h00, 1'b0, NO_RSP},
      {8'h00, 1'b0, NO_RSP},
      {8'h00, 1'b0, NO_RSP},
      {8'hA5, 1'b0, NO_RSP},
      {8'h5A, 1'b1, {KIND_DATA, 8'h5A, 8'hA5, 32'h0000_0001, 1'b1}},
      {8'h02, 1'b0, NO_RSP},
      {8'h00, 1'b0, NO_RSP},
      {8'h00, 1'b0, NO_RSP},
      {8'h00, 1'b0, NO_RSP},
      {8'h00, 1'b0, NO_RSP},
      {8'hFF, 1'b0, NO_RSP},
      {8'h00, 1'b0, NO_RSP}
   };

   length_prefixed_frame_decoder_core #(
      .HEADER_BYTES(HEADER_BYTES_DEF)
   ) uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_in_byte      (req_in_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_result_kind  (rsp_result_kind),
      .rsp_data_byte    (rsp_data_byte),
      .rsp_frame_type   (rsp_frame_type),
      .rsp_frame_length (rsp_frame_length),
      .rsp_last_of_frame(rsp_last_of_frame),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #2 clock = ~clock;

   function automatic void restart_header();
      dec_phase = ST_HEADER;
      hdr_count = '0;
      frame_len = '0;
      bytes_passed = '0;
   endfunction

   // advance the shadow decoder by one stream byte; returns 1 when a result is due
   function automatic bit decode_byte(input logic [7:0] b, output rsp_type r);
      bit got;
      got = 1'b0;
      r = NO_RSP;
      case (dec_phase)
         ST_TYPE: begin
            frame_type_q = b;
            if (frame_len == 0) begin
               r.kind = KIND_EMPTY;
               r.frame_type = b;
               r.last = 1'b1;
               got = 1'b1;
               restart_header();
            end else begin
               bytes_passed = '0;
               dec_phase = ST_PAYLOAD;
            end
         end
         ST_PAYLOAD: begin
            r.kind = KIND_DATA;
            r.data_byte = b;
            r.frame_type = frame_type_q;
            r.frame_length = frame_len;
            r.last = (32'(bytes_passed + 32'd1) == frame_len);
            got = 1'b1;
            if (r.last) begin
               restart_header();
            end else begin
               bytes_passed = bytes_passed + 32'd1;
            end
         end
         default: begin
            if (dec_phase != ST_HEADER) begin
               restart_header();
            end
            if (hdr_count < 4) begin
               frame_len = frame_len | (32'(b) << (8 * hdr_count));
            end else if (b != 8'h00) begin
               frame_len = '1;
            end
            hdr_count = hdr_count + 4'd1;
            if (hdr_count >= HEADER_BYTES_DEF) begin
               if (frame_len > max_payload_q) begin
                  r.kind = KIND_ERROR;
                  r.frame_length = frame_len;
                  got = 1'b1;
                  restart_header();
               end else begin
                  hdr_count = '0;
                  dec_phase = ST_TYPE;
               end
            end
         end
      endcase
      return got;
   endfunction

   task automatic flag_mismatch(input string msg);
      $display("%0t MISMATCH: %s", $time, msg);
      mismatches++;
   endtask

   always @(negedge clock) begin
      rsp_ready = ($urandom_range(99, 0) >= rx_idle_pct);
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         max_payload_q = MAX_PAYLOAD_RESET;
         frame_type_q = '0;
         restart_header();
      end else begin
         if (csr_write_enable) begin
            max_payload_q = csr_write_data;
         end
         if (req_valid && req_ready) begin
            if (decode_byte(req_in_byte, predicted_rsp) || row_typed) begin
               pending_results.push_back(row_typed ? row_want : predicted_rsp);
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_results.size() == 0) begin
               flag_mismatch($sformatf("result with nothing expected, kind %0d",
                                       rsp_result_kind));
            end else begin
               oldest_rsp = pending_results.pop_front();
               if (rsp_result_kind != 2'(oldest_rsp.kind))
                  flag_mismatch($sformatf("kind got %0d expected %0d",
                                          rsp_result_kind, oldest_rsp.kind));
               if (rsp_data_byte != oldest_rsp.data_byte)
                  flag_mismatch($sformatf("data_byte got 0x%02h expected 0x%02h",
                                          rsp_data_byte, oldest_rsp.data_byte));
               if (rsp_frame_type != oldest_rsp.frame_type)
                  flag_mismatch($sformatf("frame_type got 0x%02h expected 0x%02h",
                                          rsp_frame_type, oldest_rsp.frame_type));
               if (rsp_frame_length != oldest_rsp.frame_length)
                  flag_mismatch($sformatf("frame_length got 0x%08h expected 0x%08h",
                                          rsp_frame_length, oldest_rsp.frame_length));
               if (rsp_last_of_frame != oldest_rsp.last)
                  flag_mismatch($sformatf("last_of_frame got %0b expected %0b",
                                          rsp_last_of_frame, oldest_rsp.last));
            end
         end
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic typed = 1'b0,
                            input rsp_type want = NO_RSP);
      @(negedge clock);
      while ($urandom_range(99, 0) < tx_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_in_byte = b;
      row_typed = typed;
      row_want = want;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   // hold the sender until every result is in, then let the pipe settle
   task automatic drain();
      @(negedge clock);
      req_valid = 1'b0;
      row_typed = 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_max_payload(input logic [31:0] value);
      @(negedge clock);
      csr_write_enable = 1'b1;
      csr_write_data = value;
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   // one whole frame, or a header that is too long
   task automatic send_random_unit();
      int pick;
      int cap;
      logic [31:0] len;
      pick = $urandom_range(99, 0);
      if (pick < 15 && max_payload_q != 32'hFFFF_FFFF) begin
         len = max_payload_q + 32'd1 + ($urandom % (32'hFFFF_FFFF - max_payload_q));
      end else begin
         cap = (pick < 20) ? 64 : 12;
         if (max_payload_q < cap) cap = max_payload_q;
         len = (pick >= 95) ? cap : $urandom_range(cap, 0);
      end
      for (int i = 0; i < HEADER_BYTES_DEF; i++) begin
         send_byte((i < 4) ? len[8*i +: 8] : 8'h00);
      end
      if (len <= max_payload_q) begin
         send_byte(8'($urandom));
         for (int i = 0; i < len; i++) begin
            send_byte(8'($urandom));
         end
      end
   endtask

   initial begin
      logic [31:0] limit_value;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      foreach (stim_rows[i]) begin
         send_byte(stim_rows[i].in_byte, stim_rows[i].typed, stim_rows[i].want);
      end
      for (int k = 0; k < PHASES; k++) begin
         drain();
         case (k)
            0: limit_value = 32'h0000_0000;
            1: limit_value = 32'd8;
            2: limit_value = 32'hFFFF_FFFF;
            3: limit_value = MAX_PAYLOAD_RESET;
            4: limit_value = 32'hFFFF_FFFE;
            default: limit_value = $urandom_range(40, 1);
         endcase
         write_max_payload(limit_value);
         case (k / 2)
            0: begin
               tx_idle_pct = 24;
               rx_idle_pct = 45;
            end
            1: begin
               tx_idle_pct = 45;
               rx_idle_pct = 24;
            end
            default: begin
               tx_idle_pct = 0;
               rx_idle_pct = 0;
            end
         endcase
         while (items_sent < DIRECTED_ROWS + (k + 1) * RANDOM_ITEMS / PHASES) begin
            send_random_unit();
         end
      end
      drain();
      if (mismatches == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/lpfd_pkg.sv
rtl/length_prefixed_frame_decoder_core.sv
verif/length_prefixed_frame_decoder_core_tb.sv
